### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

### sv/aspg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspg_pkg
// Shared widths, register indexes and status codes of the scan point generator.
// ----------------------------------------------------------------------------
package aspg_pkg;

	localparam int LC_W       = 11;  // line_count / point_count width
	localparam int LN_W       = 10;  // line_number width
	localparam int RN_W       = 11;  // row_number width
	localparam int ST_W       = 2;   // status width
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int PEAK_RESET  = 4095;
	localparam int COUNT_RESET = 256;

	localparam logic [CFG_IDX_W-1:0] REG_PEAK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS = 3'd4;

	localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [ST_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] STATUS_RANGE = 2'd2;

endpackage

### sv/actuator_scan_point_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_scan_point_generator
// Returns the two actuator drive codes of one scan point (line, row).
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid/req_stall, line_number, row_number): one
//    transaction per scan point. req_stall stays high while a point is computed.
//  - Response channel (rsp_valid/rsp_stall, x_code, y_code, status): one
//    transaction per request, in order. A finished result sits in the output
//    register; a stalled receiver holds it there, and the next request is
//    still taken, but its result is not loaded before the old one is gone.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//    write only while no request is in flight.
//  - Steps: an out-of-range request goes straight to the response. Otherwise
//    setup is a square power product, a bit-serial divide by line_count and
//    a square root of half the power; then each of the 2N rows of the line
//    is visited twice. The shared bit-serial square root unit and the single
//    multiplier serve all of these steps; only one point is in work at a time.
//  - Reset: registers return to peak all ones, base 0, floor 0, 256 lines,
//    256 points; no response pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module actuator_scan_point_generator #(
	parameter int MAX_LINES  = 1024,
	parameter int MAX_POINTS = 1024,
	parameter int DAC_BITS   = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [aspg_pkg::LN_W-1:0]         line_number,
	input  logic [aspg_pkg::RN_W-1:0]         row_number,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [DAC_BITS-1:0]               x_code,
	output logic [DAC_BITS-1:0]               y_code,
	output logic [aspg_pkg::ST_W-1:0]         status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [aspg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aspg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int D      = DAC_BITS;
	localparam int LC_W   = aspg_pkg::LC_W;
	localparam int SQ_W   = 2 * D;          // squares of codes
	localparam int KW     = 2 * D + 1;      // row key
	localparam int MA_W   = 2 * D + 2;      // multiplier operand A
	localparam int MB_W   = (D + 1 > LC_W + 1) ? D + 1 : LC_W + 1;
	localparam int PW     = MA_W + MB_W;    // product
	localparam int TW     = PW + 1;         // scaled target
	localparam int DW     = PW + 2;         // distance
	localparam int RC_W   = D + 1;          // row counter
	localparam int CNT_W  = $clog2(PW + 1);
	localparam int CMP_W  = 13;             // room for limits up to 4096

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQMAX, ST_SQMIN, ST_KSCL, ST_DIVINIT, ST_DIV, ST_PSUM,
		ST_S_GO, ST_S_WAIT, ST_ROW, ST_LSQ, ST_RGO, ST_RWAIT, ST_A1, ST_A2,
		ST_KEY, ST_KSC, ST_DIST, ST_NEXT, ST_T1, ST_T2, ST_T3, ST_DONE
	} state_t;

	// configuration
	logic [D-1:0]    peak_q, base_q, floor_q;
	logic [LC_W-1:0] lines_q, points_q;

	// control
	state_t           state_q;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RC_W-1:0]  r_q;
	logic             pass_q;

	// datapath
	logic [aspg_pkg::LN_W-1:0] line_q;
	logic [LC_W-1:0]           j_q;
	logic [aspg_pkg::ST_W-1:0] stat_q;
	logic [SQ_W-1:0]           sqmax_q, sqmin_q, p_q, sq1_q;
	logic                      neg_q;
	logic [PW-1:0]             dvd_q;
	logic [LC_W-1:0]           rem_q;
	logic [D-1:0]              s_q, n_q, lin_q, a1_q, a2_q, best_a1_q, best_a2_q;
	logic                      half_q;
	logic signed [KW-1:0]      key_q, kmin_q, kmax_q;
	logic [LC_W-1:0]           scale_q;
	logic signed [PW-1:0]      prod_q, tgt_q;
	logic signed [TW-1:0]      target_q;
	logic [DW-1:0]             best_d_q;
	logic [D-1:0]              x_q, y_q;
	logic [aspg_pkg::ST_W-1:0] status_q;

	// combinational
	logic                  req_acc, bad_req, rsp_load, r_last, half_c, n_pos;
	logic [RC_W:0]         j_full;
	logic [D-1:0]          lin_c;
	logic signed [D+1:0]   n_s;
	logic signed [KW-1:0]  pdiff, key_c;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic [LC_W:0]         kstep;
	logic [LC_W:0]         rem_sh;
	logic                  rem_ge;
	logic signed [PW-1:0]  qs;
	logic signed [PW:0]    psum;
	logic signed [SQ_W:0]  rdiff;
	logic [SQ_W-1:0]       sq_rad;
	logic                  sq_start, sq_done;
	logic [D-1:0]          sq_root;
	logic signed [DW-1:0]  dd;
	logic [DW-1:0]         ad;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	assign bad_req = (lines_q == '0) || (points_q == '0)
		|| ({2'b00, lines_q} > CMP_W'(MAX_LINES))
		|| ({2'b00, points_q} > CMP_W'(MAX_POINTS))
		|| ({1'b0, line_number} >= lines_q)
		|| ({1'b0, row_number} >= {points_q, 1'b0});

	// mirrored sample index: rows past point_count run backwards
	assign j_full = (RC_W+1)'({points_q, 1'b0}) - 1'b1 - (RC_W+1)'(row_number);

	assign kstep = {1'b0, line_q} + 1'b1;
	assign pdiff = $signed({1'b0, sqmax_q}) - $signed({1'b0, prod_q[SQ_W-1:0]});

	// bit-serial divide step of |diff*k| by line_count
	assign rem_sh = {rem_q, dvd_q[PW-1]};
	assign rem_ge = (rem_sh >= {1'b0, lines_q});
	assign qs     = neg_q ? -$signed(dvd_q) : $signed(dvd_q);
	assign psum   = (PW+1)'(qs) + $signed({1'b0, (PW)'(sqmin_q)});

	assign n_s   = $signed({2'b00, sq_root}) - $signed({2'b00, floor_q});
	assign n_pos = (n_s > 0);

	// first half: linear code rising from floor; second half: s-1 falling
	assign half_c = (r_q >= {1'b0, n_q});
	assign lin_c  = half_c ? D'({1'b0, s_q} + {1'b0, n_q} - 1'b1 - r_q)
	                       : D'({1'b0, floor_q} + r_q);
	assign r_last = (r_q == ({n_q, 1'b0} - 1'b1));

	assign rdiff  = $signed({1'b0, p_q}) - $signed({1'b0, prod_q[SQ_W-1:0]});
	assign sq_rad = (state_q == ST_S_GO) ? (p_q >> 1)
	              : (rdiff < 0) ? '0 : rdiff[SQ_W-1:0];
	assign sq_start = (state_q == ST_S_GO) || (state_q == ST_RGO);

	assign key_c = (a1_q == '0) ? '0
	             : $signed({1'b0, sq1_q}) - $signed({1'b0, prod_q[SQ_W-1:0]});

	assign dd = DW'(prod_q) - DW'(target_q);
	assign ad = (dd < 0) ? DW'(-dd) : DW'(dd);

	aspg_isqrt #(.RW(D)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.done   (sq_done),
		.root   (sq_root)
	);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQMAX: begin
				mul_a = MA_W'(peak_q);
				mul_b = MB_W'(peak_q);
			end
			ST_SQMIN: begin
				mul_a = MA_W'(base_q);
				mul_b = MB_W'(base_q);
			end
			ST_KSCL: begin
				mul_a = MA_W'(pdiff);
				mul_b = MB_W'(kstep);
			end
			ST_LSQ: begin
				mul_a = MA_W'(lin_q);
				mul_b = MB_W'(lin_q);
			end
			ST_A1: begin
				mul_a = MA_W'(a1_q);
				mul_b = MB_W'(a1_q);
			end
			ST_A2: begin
				mul_a = MA_W'(a2_q);
				mul_b = MB_W'(a2_q);
			end
			ST_KSC: begin
				mul_a = MA_W'(key_q);
				mul_b = MB_W'(scale_q);
			end
			ST_T1: begin
				mul_a = MA_W'(kmin_q);
				mul_b = MB_W'(LC_W'(points_q - 1'b1));
			end
			ST_T2: begin
				mul_a = MA_W'(kmax_q) - MA_W'(kmin_q);
				mul_b = MB_W'(j_q);
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q   <= D'(aspg_pkg::PEAK_RESET);
			base_q   <= '0;
			floor_q  <= '0;
			lines_q  <= LC_W'(aspg_pkg::COUNT_RESET);
			points_q <= LC_W'(aspg_pkg::COUNT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				aspg_pkg::REG_PEAK:   peak_q   <= cfg_data[D-1:0];
				aspg_pkg::REG_BASE:   base_q   <= cfg_data[D-1:0];
				aspg_pkg::REG_FLOOR:  floor_q  <= cfg_data[D-1:0];
				aspg_pkg::REG_LINES:  lines_q  <= cfg_data[LC_W-1:0];
				aspg_pkg::REG_POINTS: points_q <= cfg_data[LC_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
			r_q         <= '0;
			pass_q      <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:    if (req_acc) state_q <= bad_req ? ST_DONE : ST_SQMAX;
				ST_SQMAX:   state_q <= ST_SQMIN;
				ST_SQMIN:   state_q <= ST_KSCL;
				ST_KSCL:    state_q <= ST_DIVINIT;
				ST_DIVINIT: begin
					cnt_q   <= CNT_W'(PW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						state_q <= ST_PSUM;
				end
				ST_PSUM:    state_q <= ST_S_GO;
				ST_S_GO:    state_q <= ST_S_WAIT;
				ST_S_WAIT: begin
					if (sq_done) begin
						r_q     <= '0;
						pass_q  <= 1'b0;
						state_q <= n_pos ? ST_ROW : ST_DONE;
					end
				end
				ST_ROW:     state_q <= ST_LSQ;
				ST_LSQ:     state_q <= ST_RGO;
				ST_RGO:     state_q <= ST_RWAIT;
				ST_RWAIT:   if (sq_done) state_q <= ST_A1;
				ST_A1:      state_q <= ST_A2;
				ST_A2:      state_q <= ST_KEY;
				ST_KEY:     state_q <= pass_q ? ST_KSC : ST_NEXT;
				ST_KSC:     state_q <= ST_DIST;
				ST_DIST:    state_q <= ST_NEXT;
				ST_NEXT: begin
					if (r_last) begin
						state_q <= pass_q ? ST_DONE : ST_T1;
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= ST_ROW;
					end
				end
				ST_T1: begin
					if (points_q == LC_W'(1)) begin
						r_q     <= '0;
						pass_q  <= 1'b1;
						state_q <= ST_ROW;
					end else begin
						state_q <= ST_T2;
					end
				end
				ST_T2:      state_q <= ST_T3;
				ST_T3: begin
					r_q     <= '0;
					pass_q  <= 1'b1;
					state_q <= ST_ROW;
				end
				ST_DONE:    if (rsp_load) state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					line_q <= line_number;
					j_q    <= ({1'b0, row_number} < {1'b0, points_q})
						? LC_W'(row_number) : LC_W'(j_full);
					stat_q <= bad_req ? aspg_pkg::STATUS_RANGE : aspg_pkg::STATUS_OK;
				end
			end
			ST_SQMIN: sqmax_q <= prod_q[SQ_W-1:0];
			ST_KSCL:  sqmin_q <= prod_q[SQ_W-1:0];
			ST_DIVINIT: begin
				neg_q <= prod_q[PW-1];
				dvd_q <= prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_ge ? LC_W'(rem_sh - {1'b0, lines_q}) : LC_W'(rem_sh);
				dvd_q <= {dvd_q[PW-2:0], rem_ge};
			end
			ST_PSUM: p_q <= psum[SQ_W-1:0];
			ST_S_WAIT: begin
				if (sq_done) begin
					s_q <= sq_root;
					n_q <= n_s[D-1:0];
					if (!n_pos)
						stat_q <= aspg_pkg::STATUS_EMPTY;
				end
			end
			ST_ROW: begin
				lin_q  <= lin_c;
				half_q <= half_c;
			end
			ST_RWAIT: begin
				if (sq_done) begin
					a1_q <= half_q ? sq_root : lin_q;
					a2_q <= half_q ? lin_q : sq_root;
				end
			end
			ST_A2: sq1_q <= prod_q[SQ_W-1:0];
			ST_KEY: begin
				key_q <= key_c;
				if (!pass_q) begin
					if (r_q == '0 || key_c < kmin_q)
						kmin_q <= key_c;
					if (r_q == '0 || key_c > kmax_q)
						kmax_q <= key_c;
				end
			end
			ST_T1: begin
				if (points_q == LC_W'(1)) begin
					scale_q  <= LC_W'(1);
					target_q <= TW'(kmax_q);
				end else begin
					scale_q <= LC_W'(points_q - 1'b1);
				end
			end
			ST_T2: tgt_q <= prod_q;
			ST_T3: target_q <= TW'(tgt_q) + TW'(prod_q);
			ST_DIST: begin
				// strict compare: the earliest row keeps a tie
				if (r_q == '0 || ad < best_d_q) begin
					best_d_q  <= ad;
					best_a1_q <= a1_q;
					best_a2_q <= a2_q;
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					status_q <= stat_q;
					x_q <= (stat_q == aspg_pkg::STATUS_OK) ? best_a1_q : '0;
					y_q <= (stat_q == aspg_pkg::STATUS_OK) ? best_a2_q : '0;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign x_code    = x_q;
	assign y_code    = y_q;
	assign status    = status_q;

	`ASSERT_NEXT(a_accept_starts_work, clk, arst_n, req_acc, state_q != ST_IDLE)
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, rsp_valid_q, status_q == aspg_pkg::STATUS_OK || status_q == aspg_pkg::STATUS_EMPTY || status_q == aspg_pkg::STATUS_RANGE)
	`ASSERT_IMPLIES(a_fault_zero_codes, clk, arst_n, rsp_valid_q && status_q != aspg_pkg::STATUS_OK, x_q == '0 && y_q == '0)
	`ASSERT_NEXT(a_root_waited, clk, arst_n, sq_start, state_q == ST_S_WAIT || state_q == ST_RWAIT)

endmodule

### sv/aspg_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspg_isqrt
// Iterative rounded integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module aspg_isqrt #(
	parameter int RW = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] rad,
	output logic            done,
	output logic [RW-1:0]   root
);

	localparam int CW = $clog2(RW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [2*RW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;

	logic [RW+3:0] cur;
	logic [RW+3:0] trial;
	logic          ge;

	assign cur   = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = (cur >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// digit recurrence; last cycle rounds (remainder above root means round up)
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				if ({2'b00, root_q} < rem_q)
					root_q <= root_q + 1'b1;
			end else begin
				rad_q <= rad_q << 2;
				if (ge) begin
					rem_q  <= (RW+2)'(cur - trial);
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= (RW+2)'(cur);
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Scan point generator check: directed table, random configs, long hold-off.
// Every request's drive codes and status are predicted here and compared, in
// order, with what comes out of the response channel.
// ----------------------------------------------------------------------------
module tb;

	localparam int CODE_W = 12;
	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic [CODE_W-1:0]         x;
		logic [CODE_W-1:0]         y;
		logic [aspg_pkg::ST_W-1:0] st;
	} scan_point_t;

	// Directed rows: either a register write or a request.
	typedef struct {
		bit                             is_write;
		logic [aspg_pkg::CFG_IDX_W-1:0] idx;
		int                             data;
		int                             line;
		int                             row;
		bit                             typed;    // expected value given in the row
		scan_point_t                    point;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [aspg_pkg::LN_W-1:0] line_number = '0;
	logic [aspg_pkg::RN_W-1:0] row_number = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	logic [CODE_W-1:0] x_code;
	logic [CODE_W-1:0] y_code;
	logic [aspg_pkg::ST_W-1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [aspg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [aspg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Register shadow used by the predictor
	int peak_code = aspg_pkg::PEAK_RESET;
	int base_code = 0;
	int floor_code = 0;
	int lines_cfg = aspg_pkg::COUNT_RESET;
	int points_cfg = aspg_pkg::COUNT_RESET;

	scan_point_t pending_points[$];
	int errors = 0;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;      // back-to-back stretch on both sides
	bit hold_rsp = 1'b0;     // request one long receiver hold-off

	actuator_scan_point_generator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.line_number(line_number),
		.row_number (row_number),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.x_code     (x_code),
		.y_code     (y_code),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor
	// Square root rounded to nearest; non-positive arguments give 0.
	function automatic longint root_nearest(longint v);
		longint r;
		if (v <= 0)
			return 0;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
				r = r | (64'd1 << b);
		end
		// round up once the remainder passes r (no exact halves exist)
		if (v - r * r > r)
			r++;
		return r;
	endfunction

	// Code pair of column row r: linear segment first, then its mirror.
	function automatic void column_pair(longint r, longint n, longint s, longint p,
			output longint a1, output longint a2);
		longint lin;
		if (r < n) begin
			lin = s - n + r;
			a1 = lin;
			a2 = root_nearest(p - lin * lin);
		end else begin
			lin = s - 1 - (r - n);
			a1 = root_nearest(p - lin * lin);
			a2 = lin;
		end
	endfunction

	function automatic longint sort_key(longint a1, longint a2);
		return (a1 == 0) ? 0 : a1 * a1 - a2 * a2;
	endfunction

	function automatic scan_point_t scan_point(int line, int row);
		scan_point_t pt;
		longint p, s, n, j, kmin, kmax, k, scale, target, delta, best_delta, best;
		longint a1, a2, lc, m, hi, lo;
		pt = '0;
		lc = lines_cfg;
		m = points_cfg;
		hi = peak_code;
		lo = base_code;
		if (lc == 0 || lc > 1024 || m == 0 || m > 1024 || line >= lc || row >= 2 * m) begin
			pt.st = aspg_pkg::STATUS_RANGE;
			return pt;
		end
		// SV signed division truncates toward zero, matching a downward power ramp
		p = (hi * hi - lo * lo) * (line + 1) / lc + lo * lo;
		s = root_nearest(p / 2);
		n = s - floor_code;
		if (n <= 0) begin
			pt.st = aspg_pkg::STATUS_EMPTY;
			return pt;
		end
		j = (row < m) ? row : 2 * m - 1 - row;
		column_pair(0, n, s, p, a1, a2);
		kmin = sort_key(a1, a2);
		kmax = kmin;
		for (longint r = 1; r < 2 * n; r++) begin
			column_pair(r, n, s, p, a1, a2);
			k = sort_key(a1, a2);
			if (k < kmin) kmin = k;
			if (k > kmax) kmax = k;
		end
		if (m == 1) begin
			scale = 1;
			target = kmax;
		end else begin
			scale = m - 1;
			target = scale * kmin + (kmax - kmin) * j;
		end
		// nearest key, first row wins ties; all in exact integers
		best_delta = -1;
		best = 0;
		for (longint r = 0; r < 2 * n; r++) begin
			column_pair(r, n, s, p, a1, a2);
			delta = scale * sort_key(a1, a2) - target;
			if (delta < 0) delta = -delta;
			if (best_delta < 0 || delta < best_delta) begin
				best_delta = delta;
				best = r;
			end
		end
		column_pair(best, n, s, p, a1, a2);
		pt.x = a1[CODE_W-1:0];
		pt.y = a2[CODE_W-1:0];
		pt.st = aspg_pkg::STATUS_OK;
		return pt;
	endfunction

	// ---------------------------------------------------------------- drivers
	task automatic write_reg(logic [aspg_pkg::CFG_IDX_W-1:0] idx, int data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[aspg_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			aspg_pkg::REG_PEAK:   peak_code = data & 12'hFFF;
			aspg_pkg::REG_BASE:   base_code = data & 12'hFFF;
			aspg_pkg::REG_FLOOR:  floor_code = data & 12'hFFF;
			aspg_pkg::REG_LINES:  lines_cfg = data & 11'h7FF;
			aspg_pkg::REG_POINTS: points_cfg = data & 11'h7FF;
			default: ;
		endcase
	endtask

	// Wait until every expected point has come back, then let the block settle.
	task automatic drain();
		wait (pending_points.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// One request transaction; valid stays high across back-to-back requests.
	task automatic send_point(int line, int row, bit typed, scan_point_t typed_pt);
		int gap;
		scan_point_t pt;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt = typed ? typed_pt : scan_point(line, row);
		req_valid <= 1'b1;
		line_number <= line[aspg_pkg::LN_W-1:0];
		row_number <= row[aspg_pkg::RN_W-1:0];
		do @(posedge clk); while (req_stall);
		pending_points.push_back(pt);
	endtask

	// Receiver: random hold-offs, a long one on request, or none in bursts.
	initial begin : rsp_side
		int n;
		forever begin
			if (hold_rsp) begin
				n = HOLD_CYCLES;
				hold_rsp = 1'b0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 12);
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// Response checker: each accepted transaction against the oldest prediction.
	always @(posedge clk) begin
		scan_point_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_points.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
			end else begin
				want = pending_points.pop_front();
				if (x_code !== want.x) begin
					$error("x_code expected %0d got %0d", want.x, x_code);
					errors++;
				end
				if (y_code !== want.y) begin
					$error("y_code expected %0d got %0d", want.y, y_code);
					errors++;
				end
				if (status !== want.st) begin
					$error("status expected %0d got %0d", want.st, status);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction on either channel.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[actuator_scan_point_generator] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus
	function automatic plan_row_t wr(logic [aspg_pkg::CFG_IDX_W-1:0] idx, int data);
		plan_row_t pr;
		pr = '{default: 0};
		pr.is_write = 1'b1;
		pr.idx = idx;
		pr.data = data;
		return pr;
	endfunction

	function automatic plan_row_t rq(int line, int row);
		plan_row_t pr;
		pr = '{default: 0};
		pr.line = line;
		pr.row = row;
		return pr;
	endfunction

	function automatic plan_row_t rq_typed(int line, int row, logic [aspg_pkg::ST_W-1:0] st);
		plan_row_t pr;
		pr = rq(line, row);
		pr.typed = 1'b1;
		pr.point = '{x: '0, y: '0, st: st};
		return pr;
	endfunction

	initial begin : stimulus
		plan_row_t plan[$];
		scan_point_t none;
		int line, row;
		none = '0;

		// Reset values: full-scale peak, 256 lines, 256 points
		plan.push_back(rq(0, 0));
		plan.push_back(rq(0, 511));
		plan.push_back(rq(0, 255));
		plan.push_back(rq(0, 256));
		plan.push_back(rq_typed(256, 0, aspg_pkg::STATUS_RANGE));
		plan.push_back(rq_typed(0, 512, aspg_pkg::STATUS_RANGE));
		plan.push_back(rq_typed(1023, 2047, aspg_pkg::STATUS_RANGE));
		// Single sample per half line picks the largest key
		plan.push_back(wr(aspg_pkg::REG_POINTS, 1));
		plan.push_back(rq(0, 0));
		plan.push_back(rq(0, 1));
		plan.push_back(rq_typed(0, 2, aspg_pkg::STATUS_RANGE));
		// Largest point and line counts
		plan.push_back(wr(aspg_pkg::REG_POINTS, 1024));
		plan.push_back(wr(aspg_pkg::REG_LINES, 1024));
		plan.push_back(rq(0, 2047));
		plan.push_back(rq(0, 1024));
		// Counts of zero or past the maximum are rejected
		plan.push_back(wr(aspg_pkg::REG_LINES, 0));
		plan.push_back(rq_typed(0, 0, aspg_pkg::STATUS_RANGE));
		plan.push_back(wr(aspg_pkg::REG_LINES, 2047));
		plan.push_back(wr(aspg_pkg::REG_POINTS, 0));
		plan.push_back(rq_typed(0, 0, aspg_pkg::STATUS_RANGE));
		plan.push_back(wr(aspg_pkg::REG_LINES, 1024));
		plan.push_back(wr(aspg_pkg::REG_POINTS, 1025));
		plan.push_back(rq_typed(0, 0, aspg_pkg::STATUS_RANGE));
		plan.push_back(wr(aspg_pkg::REG_POINTS, 16));
		// Floor at or above the root power: empty line
		plan.push_back(wr(aspg_pkg::REG_FLOOR, 4095));
		plan.push_back(rq_typed(0, 0, aspg_pkg::STATUS_EMPTY));
		plan.push_back(wr(aspg_pkg::REG_BASE, 4095));
		plan.push_back(rq_typed(1023, 31, aspg_pkg::STATUS_EMPTY));
		plan.push_back(wr(aspg_pkg::REG_FLOOR, 0));
		// Peak below base: power ramps downward
		plan.push_back(wr(aspg_pkg::REG_PEAK, 0));
		plan.push_back(wr(aspg_pkg::REG_BASE, 200));
		plan.push_back(rq(0, 5));
		plan.push_back(rq(1023, 20));
		// Zero power everywhere: empty line
		plan.push_back(wr(aspg_pkg::REG_BASE, 0));
		plan.push_back(rq_typed(7, 3, aspg_pkg::STATUS_EMPTY));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				req_valid <= 1'b0;
				drain();
				write_reg(plan[i].idx, plan[i].data);
				@(posedge clk);
			end else begin
				send_point(plan[i].line, plan[i].row, plan[i].typed, plan[i].point);
			end
		end

		// Random phases: small drive codes keep lines short; phase 2 runs back-to-back
		for (int ph = 0; ph < 6; ph++) begin
			req_valid <= 1'b0;
			drain();
			no_idle = (ph == 2);
			write_reg(aspg_pkg::REG_PEAK, $urandom_range(0, 160));
			write_reg(aspg_pkg::REG_BASE, $urandom_range(0, 160));
			write_reg(aspg_pkg::REG_FLOOR, ($urandom_range(0, 3) == 0)
				? $urandom_range(0, 4095) : $urandom_range(0, 60));
			write_reg(aspg_pkg::REG_LINES, (ph % 3 == 0) ? 1024 : $urandom_range(1, 1024));
			write_reg(aspg_pkg::REG_POINTS, (ph == 1) ? 1 : (ph == 4) ? 1024
				: $urandom_range(1, 1024));
			@(posedge clk);
			for (int k = 0; k < 12; k++) begin
				line = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
					: $urandom_range(0, lines_cfg - 1);
				row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
					: $urandom_range(0, 2 * points_cfg - 1);
				send_point(line, row, 1'b0, none);
			end
		end
		no_idle = 1'b0;

		// Long receiver hold-off while requests keep coming: block must back up
		req_valid <= 1'b0;
		drain();
		write_reg(aspg_pkg::REG_PEAK, 40);
		write_reg(aspg_pkg::REG_LINES, 4);
		write_reg(aspg_pkg::REG_POINTS, 8);
		@(posedge clk);
		hold_rsp = 1'b1;
		for (int k = 0; k < 12; k++)
			send_point($urandom_range(0, 5), $urandom_range(0, 17), 1'b0, none);
		req_valid <= 1'b0;

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("[actuator_scan_point_generator] OK");
		else
			$display("[actuator_scan_point_generator] ERROR");
		$finish;
	end

endmodule
